// ===== src/spil_pkg.sv =====
// shared types and constants for the sorted priority insert list
`default_nettype none

package spil_pkg;

  localparam int PRIO_W = 32;
  localparam int VAL_W  = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DUMP   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_INSERTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_ENTRY    = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

  // broadcast command from the controller to every cell
  typedef struct packed {
    logic ins;
    logic rot;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/spil_cell.sv =====
// one storage cell of the sorted chain: holds an entry and trades with its neighbors
`default_nettype none

module spil_cell (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire spil_pkg::cell_cmd_t               cmd,
  input  wire logic        [spil_pkg::PRIO_W-1:0] new_prio,
  input  wire logic signed [spil_pkg::VAL_W-1:0]  new_val,
  input  wire logic                              prev_valid,
  input  wire logic                              prev_gt,
  input  wire logic        [spil_pkg::PRIO_W-1:0] prev_prio,
  input  wire logic signed [spil_pkg::VAL_W-1:0]  prev_val,
  input  wire logic                              next_valid,
  input  wire logic        [spil_pkg::PRIO_W-1:0] next_prio,
  input  wire logic signed [spil_pkg::VAL_W-1:0]  next_val,
  input  wire logic        [spil_pkg::PRIO_W-1:0] head_prio,
  input  wire logic signed [spil_pkg::VAL_W-1:0]  head_val,
  output logic                                   valid,
  output logic                                   gt,
  output logic             [spil_pkg::PRIO_W-1:0] prio,
  output logic signed      [spil_pkg::VAL_W-1:0]  val
);

  logic                               valid_next;
  logic        [spil_pkg::PRIO_W-1:0] prio_next;
  logic signed [spil_pkg::VAL_W-1:0]  val_next;
  logic                               tail;

  assign gt   = valid && (prio > new_prio);
  assign tail = valid && !next_valid;

  always_comb begin
    valid_next = valid;
    prio_next  = prio;
    val_next   = val;
    if (cmd.ins) begin
      valid_next = valid | prev_valid;
      if (prev_gt) begin
        // everything from the insert point on moves one cell toward the tail
        prio_next = prev_prio;
        val_next  = prev_val;
      end else if (prev_valid && (!valid || gt)) begin
        prio_next = new_prio;
        val_next  = new_val;
      end
    end else if (cmd.rot && valid) begin
      // rotate toward the head, the tail wraps to the old head
      if (tail) begin
        prio_next = head_prio;
        val_next  = head_val;
      end else begin
        prio_next = next_prio;
        val_next  = next_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    prio <= prio_next;
    val  <= val_next;
  end

endmodule

`default_nettype wire

// ===== src/spil_ctrl.sv =====
// sequencer: input handshake, entry count, dump walk and output register
`default_nettype none

module spil_ctrl #(
  parameter int CAPACITY = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              operation,
  input  wire logic        [spil_pkg::PRIO_W-1:0] head_prio,
  input  wire logic signed [spil_pkg::VAL_W-1:0]  head_val,
  output spil_pkg::cell_cmd_t                    cmd,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic             [1:0]                 kind,
  output logic             [spil_pkg::PRIO_W-1:0] out_priority,
  output logic signed      [spil_pkg::VAL_W-1:0]  out_value,
  output logic                                   last
);

  localparam int CW = $clog2(CAPACITY + 1);

  spil_pkg::state_t state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    rem, rem_next;

  logic                               out_valid_next;
  spil_pkg::kind_t                    kind_r, kind_next;
  logic        [spil_pkg::PRIO_W-1:0] out_priority_next;
  logic signed [spil_pkg::VAL_W-1:0]  out_value_next;
  logic                               last_next;

  logic out_free;
  logic accept;
  logic full;

  assign out_free = !out_valid || !out_stall;
  assign full     = (count == CW'(CAPACITY));
  assign in_stall = (state != spil_pkg::ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign kind     = kind_r;

  always_comb begin
    state_next        = state;
    count_next        = count;
    rem_next          = rem;
    cmd               = '0;
    out_valid_next    = out_valid && out_stall;
    kind_next         = kind_r;
    out_priority_next = out_priority;
    out_value_next    = out_value;
    last_next         = last;
    case (state)
      spil_pkg::ST_IDLE: begin
        if (accept) begin
          out_priority_next = '0;
          out_value_next    = '0;
          last_next         = 1'b1;
          if (spil_pkg::op_t'(operation) == spil_pkg::OP_INSERT) begin
            out_valid_next = 1'b1;
            if (full) begin
              kind_next = spil_pkg::KIND_FULL;
            end else begin
              kind_next  = spil_pkg::KIND_INSERTED;
              cmd.ins    = 1'b1;
              count_next = count + CW'(1);
            end
          end else if (count == '0) begin
            out_valid_next = 1'b1;
            kind_next      = spil_pkg::KIND_EMPTY;
          end else begin
            rem_next   = count;
            state_next = spil_pkg::ST_DUMP;
          end
        end
      end
      spil_pkg::ST_DUMP: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          kind_next         = spil_pkg::KIND_ENTRY;
          out_priority_next = head_prio;
          out_value_next    = head_val;
          last_next         = (rem == CW'(1));
          cmd.rot           = 1'b1;
          rem_next          = rem - CW'(1);
          if (rem == CW'(1)) begin
            state_next = spil_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = spil_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spil_pkg::ST_IDLE;
      count     <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rem       <= rem_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_next;
    out_priority <= out_priority_next;
    out_value    <= out_value_next;
    last         <= last_next;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_dump_rem: assert property (@(posedge clk) disable iff (rst)
    (state == spil_pkg::ST_DUMP) |-> (rem != '0 && rem <= count))
    else $error("dump walk counter out of range");

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ins && cmd.rot))
    else $error("insert and rotate at once");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> (count == $past(count) + CW'(1)))
    else $error("insert did not bump count");

  a_dump_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.rot |=> $stable(count))
    else $error("count changed during dump");
`endif

endmodule

`default_nettype wire

// ===== src/sorted_priority_insert_list.sv =====
// Sorted priority insert list: a chain of CAPACITY cells kept in ascending priority.
// Input channel (in_valid/in_stall) carries operation, priority_req and data_value;
// operation 0 inserts an entry ahead of the first stored entry of strictly greater
// priority, operation 1 dumps all entries in order.
// Output channel (out_valid/out_stall) carries kind, out_priority, out_value, last.
// Insert: every cell compares its priority with the new one in parallel and the chain
// shifts toward the tail in one step; the result (inserted or full) is registered and
// appears in the cycle after accept. Inserts are taken one per cycle while the output
// is drained.
// Dump of n entries: the chain rotates one cell toward the head per output item, so
// results come at one per cycle while the output is not stalled, each registered and
// the last marked; the input stalls until the walk ends. A dump of an empty list gives
// one empty item. A stalled output holds its item and the chain waits with it.
// Reset clears the occupancy bits and the controller; no clearing pass is needed.
`default_nettype none

module sorted_priority_insert_list #(
  parameter int CAPACITY = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              operation,
  input  wire logic        [spil_pkg::PRIO_W-1:0] priority_req,
  input  wire logic signed [spil_pkg::VAL_W-1:0]  data_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic             [1:0]                 kind,
  output logic             [spil_pkg::PRIO_W-1:0] out_priority,
  output logic signed      [spil_pkg::VAL_W-1:0]  out_value,
  output logic                                   last
);

  spil_pkg::cell_cmd_t cmd;

  logic                               cell_valid [CAPACITY];
  logic                               cell_gt    [CAPACITY];
  logic        [spil_pkg::PRIO_W-1:0] cell_prio  [CAPACITY];
  logic signed [spil_pkg::VAL_W-1:0]  cell_val   [CAPACITY];

  spil_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .head_prio    (cell_prio[0]),
    .head_val     (cell_val[0]),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .out_priority (out_priority),
    .out_value    (out_value),
    .last         (last)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                               p_valid;
    logic                               p_gt;
    logic        [spil_pkg::PRIO_W-1:0] p_prio;
    logic signed [spil_pkg::VAL_W-1:0]  p_val;
    logic                               n_valid;
    logic        [spil_pkg::PRIO_W-1:0] n_prio;
    logic signed [spil_pkg::VAL_W-1:0]  n_val;

    if (i == 0) begin : g_head
      // the head always has a filled neighbor that is not greater
      assign p_valid = 1'b1;
      assign p_gt    = 1'b0;
      assign p_prio  = priority_req;
      assign p_val   = data_value;
    end else begin : g_mid
      assign p_valid = cell_valid[i-1];
      assign p_gt    = cell_gt[i-1];
      assign p_prio  = cell_prio[i-1];
      assign p_val   = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_prio  = cell_prio[0];
      assign n_val   = cell_val[0];
    end else begin : g_body
      assign n_valid = cell_valid[i+1];
      assign n_prio  = cell_prio[i+1];
      assign n_val   = cell_val[i+1];
    end

    spil_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .new_prio   (priority_req),
      .new_val    (data_value),
      .prev_valid (p_valid),
      .prev_gt    (p_gt),
      .prev_prio  (p_prio),
      .prev_val   (p_val),
      .next_valid (n_valid),
      .next_prio  (n_prio),
      .next_val   (n_val),
      .head_prio  (cell_prio[0]),
      .head_val   (cell_val[0]),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i]),
      .prio       (cell_prio[i]),
      .val        (cell_val[i])
    );
  end

endmodule

`default_nettype wire

// ===== dv/sorted_priority_insert_list_tb.sv =====
// testbench for the sorted priority insert list: random-paced stimulus checked against a list model
`timescale 1ns / 1ps

module sorted_priority_insert_list_tb;

  localparam int LIST_DEPTH = 16;

  typedef struct {
    spil_pkg::kind_t    kind;
    logic [31:0]        prio;
    logic signed [31:0] val;
    logic               last;
  } list_result_t;

  class ListScoreboard;
    logic [31:0]        prio_list[$];
    logic signed [31:0] val_list[$];
    list_result_t       awaited_results[$];
    int errors;
    int checked;
    int n_inserted;
    int n_rejected;
    int n_dumps;

    function new();
      errors = 0;
      checked = 0;
      n_inserted = 0;
      n_rejected = 0;
      n_dumps = 0;
    endfunction

    function void push_result(spil_pkg::kind_t k, logic [31:0] p, logic signed [31:0] v,
                              logic l);
      list_result_t r;
      r.kind = k;
      r.prio = p;
      r.val  = v;
      r.last = l;
      awaited_results.push_back(r);
    endfunction

    // update the modeled list and queue the results this request should produce
    function void apply_request(spil_pkg::op_t op, logic [31:0] p, logic signed [31:0] v);
      int pos;
      if (op == spil_pkg::OP_INSERT) begin
        if (prio_list.size() >= LIST_DEPTH) begin
          n_rejected++;
          push_result(spil_pkg::KIND_FULL, '0, '0, 1'b1);
        end else begin
          pos = prio_list.size();
          // first entry with strictly greater priority; ties stay in arrival order
          for (int j = 0; j < prio_list.size(); j++) begin
            if (prio_list[j] > p) begin
              pos = j;
              break;
            end
          end
          prio_list.insert(pos, p);
          val_list.insert(pos, v);
          n_inserted++;
          push_result(spil_pkg::KIND_INSERTED, '0, '0, 1'b1);
        end
      end else begin
        n_dumps++;
        if (prio_list.size() == 0) begin
          push_result(spil_pkg::KIND_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int j = 0; j < prio_list.size(); j++)
            push_result(spil_pkg::KIND_ENTRY, prio_list[j], val_list[j],
                        j == prio_list.size() - 1);
        end
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 30)
        $display("mismatch on %s: got %0h, expected %0h (result %0d)", what, got, want, checked);
    endtask

    task check_result(logic [1:0] k, logic [31:0] p, logic [31:0] v, logic l);
      list_result_t exp_r;
      if (awaited_results.size() == 0) begin
        report("unexpected result", {30'd0, k}, '0);
      end else begin
        exp_r = awaited_results.pop_front();
        if (k !== exp_r.kind) report("kind", {30'd0, k}, {30'd0, exp_r.kind});
        if (p !== exp_r.prio) report("out_priority", p, exp_r.prio);
        if (v !== exp_r.val) report("out_value", v, exp_r.val);
        if (l !== exp_r.last) report("last", {31'd0, l}, {31'd0, exp_r.last});
      end
      checked++;
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               operation;
  logic [31:0]        priority_req;
  logic signed [31:0] data_value;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         kind;
  logic [31:0]        out_priority;
  logic signed [31:0] out_value;
  logic               last;

  ListScoreboard board = new();
  int  burst_left = 0;
  bit  flood_phase = 1'b0;

  sorted_priority_insert_list #(.CAPACITY(LIST_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .priority_req(priority_req),
    .data_value(data_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .out_priority(out_priority),
    .out_value(out_value),
    .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // offer one item and hold it until the block takes it
  task automatic send_item(spil_pkg::op_t op, logic [31:0] p, logic signed [31:0] v);
    in_valid <= 1'b1;
    operation <= op;
    priority_req <= p;
    data_value <= v;
    do @(posedge clk); while (in_stall);
    board.apply_request(op, p, v);
  endtask

  // sender pacing: bursts of random length separated by random gaps
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  function automatic logic [31:0] pick_priority();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(kind, out_priority, out_value, last);
  end

  // receiver stall pattern, with one long hold-off once the random part runs
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      if (flood_phase && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        for (int i = 0; i < 300; i++) @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(5, 40)) @(posedge clk);
      end else begin
        repeat ($urandom_range(5, 40)) begin
          out_stall <= ($urandom_range(0, 2) == 0);
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    operation <= spil_pkg::OP_INSERT;
    priority_req <= '0;
    data_value <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty dump, extremes, ties at both ends, fill up, full insert, full dump
    send_item(spil_pkg::OP_DUMP, $urandom, $urandom); pace();
    send_item(spil_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'sh8000_0000); pace();
    send_item(spil_pkg::OP_INSERT, 32'h0, 32'sh7FFF_FFFF); pace();
    send_item(spil_pkg::OP_INSERT, 32'd5, -32'sd1); pace();
    send_item(spil_pkg::OP_INSERT, 32'd5, 32'sd1); pace();
    send_item(spil_pkg::OP_INSERT, 32'd5, 32'sd2); pace();
    send_item(spil_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'sd3); pace();
    send_item(spil_pkg::OP_INSERT, 32'h0, 32'sd4); pace();
    send_item(spil_pkg::OP_INSERT, 32'h8000_0000, 32'sh5555_AAAA); pace();
    send_item(spil_pkg::OP_DUMP, 32'h0, 32'sh0); pace();
    repeat (LIST_DEPTH - 8) begin
      send_item(spil_pkg::OP_INSERT, $urandom_range(0, 10), $urandom);
      pace();
    end
    send_item(spil_pkg::OP_INSERT, 32'd3, 32'sd99); pace();
    send_item(spil_pkg::OP_DUMP, 32'hFFFF_FFFF, -32'sd1); pace();

    // random part: inserts against the full list mixed with full dumps
    flood_phase = 1'b1;
    repeat (480) begin
      if ($urandom_range(0, 9) < 3)
        send_item(spil_pkg::OP_DUMP, $urandom, $urandom);
      else
        send_item(spil_pkg::OP_INSERT, pick_priority(), $urandom);
      pace();
    end
    in_valid <= 1'b0;

    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d accepted inserts, %0d rejected inserts, %0d dumps",
             board.n_inserted, board.n_rejected, board.n_dumps);
    $display("checked %0d results with %0d mismatches", board.checked, board.errors);
    if (board.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
